FILE: hdl/bcf_pkg.sv
`timescale 1ns / 1ps
// bcf_pkg: shared constants, character codes and bracket helpers of the bracket close finder
// no dependencies; used by bracket_close_finder and bcf_checker

package bcf_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF   = 32;
    localparam int POSITION_BITS_DEF = 16;

    // field widths fixed by the stream format
    localparam int CHAR_W   = 16;
    localparam int OFFSET_W = 16;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    // bit places inside tuser
    localparam int S_USER_FIRST = 0;
    localparam int M_USER_FOUND = 0;
    localparam int M_USER_OVF   = 1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [1:0]        t_kind;

    // character codes
    localparam t_char CH_LT     = 16'h003C;
    localparam t_char CH_GT     = 16'h003E;
    localparam t_char CH_LPAR   = 16'h0028;
    localparam t_char CH_RPAR   = 16'h0029;
    localparam t_char CH_LSQ    = 16'h005B;
    localparam t_char CH_RSQ    = 16'h005D;
    localparam t_char CH_LCUR   = 16'h007B;
    localparam t_char CH_RCUR   = 16'h007D;
    localparam t_char CH_MINUS  = 16'h002D;
    localparam t_char CH_DQUOTE = 16'h0022;
    localparam t_char CH_SQUOTE = 16'h0027;
    localparam t_char CH_BSLASH = 16'h005C;

    // bracket kinds held on the stack
    localparam t_kind KIND_ANGLE = 2'd0;
    localparam t_kind KIND_ROUND = 2'd1;
    localparam t_kind KIND_SQUARE = 2'd2;
    localparam t_kind KIND_CURLY = 2'd3;

    // previous character classes
    localparam logic [1:0] PREV_OTHER  = 2'd0;
    localparam logic [1:0] PREV_MINUS  = 2'd1;
    localparam logic [1:0] PREV_ESCAPE = 2'd2;

    // opening bracket test
    function automatic logic is_open(input t_char c);
        logic r;
        r = (c == CH_LT) || (c == CH_LPAR) || (c == CH_LSQ) || (c == CH_LCUR);
        return r;
    endfunction

    // closing bracket test
    function automatic logic is_close(input t_char c);
        logic r;
        r = (c == CH_GT) || (c == CH_RPAR) || (c == CH_RSQ) || (c == CH_RCUR);
        return r;
    endfunction

    // kind of an opening or closing bracket
    function automatic t_kind bracket_kind(input t_char c);
        t_kind k;
        case (c)
            CH_LT, CH_GT:     k = KIND_ANGLE;
            CH_LPAR, CH_RPAR: k = KIND_ROUND;
            CH_LSQ, CH_RSQ:   k = KIND_SQUARE;
            CH_LCUR, CH_RCUR: k = KIND_CURLY;
            default:          k = KIND_ANGLE;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/bracket_close_finder.sv
`timescale 1ns / 1ps
// bracket_close_finder: top level, scans text items and reports where bracket nesting closes
// depends on bcf_pkg and bcf_ram
//
// channel  direction  tdata                               tuser                  tlast
// s        in         char_code[15:0] start_offset[31:16] first_char[0]          last_char
// m        out        position[15:0]                      found[0] overflow[1]   -
//
// one item per cycle while s is not stalled; a result appears on m in the cycle after the item that caused it
// the stack sits in a one-read one-write memory; the top entry is held in a register
// and the entry below it is read ahead each cycle, so a pop needs no extra cycle
// s stalls only while a result waits in the output register and m is not ready
// reset idles the block until an item with first_char; no clearing pass is needed

module bracket_close_finder #(
    parameter int STACK_DEPTH   = bcf_pkg::STACK_DEPTH_DEF,
    parameter int POSITION_BITS = bcf_pkg::POSITION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bcf_pkg::S_DATA_W-1:0] i_s_tdata,   // char_code, start_offset
    input  logic [bcf_pkg::S_USER_W-1:0] i_s_tuser,   // first_char
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bcf_pkg::M_DATA_W-1:0] o_m_tdata,   // position
    output logic [bcf_pkg::M_USER_W-1:0] o_m_tuser    // found, overflow
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // search state
    logic [CNT_W-1:0]          r_count, n_count;
    bcf_pkg::t_kind            r_top, n_top;
    logic                      r_inq, n_inq;
    logic                      r_single, n_single;
    logic [1:0]                r_prev, n_prev;
    logic [POSITION_BITS-1:0]  r_pos, n_pos;
    logic                      r_done, n_done;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic                          r_found, n_found;
    logic                          r_ovf, n_ovf;
    logic [POSITION_BITS-1:0]      r_res_pos, n_res_pos;

    // stack memory access
    logic                  w_wr_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [CNT_W-1:0]      w_rd_cnt;
    bcf_pkg::t_kind        w_below;

    // input fields
    bcf_pkg::t_char        w_char;
    logic [31:0]           w_start32;
    logic [31:0]           w_pos32;
    logic                  w_first;
    logic                  w_acc;

    assign w_char    = i_s_tdata[bcf_pkg::CHAR_W-1:0];
    assign w_start32 = 32'(i_s_tdata[bcf_pkg::CHAR_W +: bcf_pkg::OFFSET_W]);
    assign w_first   = i_s_tuser[bcf_pkg::S_USER_FIRST];
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc     = i_s_tvalid && o_s_tready;

    // stack memory: entries at index below count, read ahead at the entry under the top
    bcf_ram #(
        .WIDTH(2),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(n_top),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_below)
    );

    assign w_rd_cnt  = n_count - CNT_W'(2);
    assign w_rd_addr = w_rd_cnt[ADDR_W-1:0];

    // write address is the current count, zero after a restart clear
    assign w_wr_addr = w_first ? '0 : r_count[ADDR_W-1:0];

    // per-item scan logic
    always_comb begin
        logic [CNT_W-1:0] c_count;
        logic             c_inq;
        logic             c_single;
        logic [1:0]       c_prev;
        bcf_pkg::t_char   c_quote;
        logic             c_arrow;
        logic             c_emit;

        n_count     = r_count;
        n_top       = r_top;
        n_inq       = r_inq;
        n_single    = r_single;
        n_prev      = r_prev;
        n_pos       = r_pos;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_m_tready;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_res_pos   = r_res_pos;
        w_wr_en     = 1'b0;

        c_count  = r_count;
        c_inq    = r_inq;
        c_single = r_single;
        c_prev   = r_prev;
        c_quote  = r_single ? bcf_pkg::CH_SQUOTE : bcf_pkg::CH_DQUOTE;
        c_arrow  = 1'b0;
        c_emit   = 1'b0;

        if (w_acc && (w_first || !r_done)) begin
            // restart clears the search, otherwise the position advances and saturates
            if (w_first) begin
                c_count  = '0;
                c_inq    = 1'b0;
                c_single = 1'b0;
                c_prev   = bcf_pkg::PREV_OTHER;
                c_quote  = bcf_pkg::CH_DQUOTE;
                n_pos    = w_start32[POSITION_BITS-1:0];
                n_done   = 1'b0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + POSITION_BITS'(1);
            end
            n_count  = c_count;
            n_inq    = c_inq;
            n_single = c_single;
            n_prev   = c_prev;

            if (c_inq) begin
                // inside a literal
                if (c_prev == bcf_pkg::PREV_ESCAPE) begin
                    n_prev = bcf_pkg::PREV_OTHER;
                end else if (w_char == c_quote) begin
                    n_inq = 1'b0;
                end else if (w_char == bcf_pkg::CH_BSLASH) begin
                    n_prev = bcf_pkg::PREV_ESCAPE;
                end else begin
                    n_prev = (w_char == bcf_pkg::CH_MINUS) ? bcf_pkg::PREV_MINUS
                                                           : bcf_pkg::PREV_OTHER;
                end
                if (i_s_tlast) begin
                    c_emit  = 1'b1;
                    n_found = 1'b0;
                    n_ovf   = 1'b0;
                    n_res_pos = '0;
                end
            end else if (w_char == bcf_pkg::CH_DQUOTE || w_char == bcf_pkg::CH_SQUOTE) begin
                // opening quote
                n_inq    = 1'b1;
                n_single = (w_char == bcf_pkg::CH_SQUOTE);
                n_prev   = bcf_pkg::PREV_OTHER;
                if (i_s_tlast) begin
                    c_emit  = 1'b1;
                    n_found = 1'b0;
                    n_ovf   = 1'b0;
                    n_res_pos = '0;
                end
            end else if (bcf_pkg::is_open(w_char) && c_count == CNT_FULL) begin
                // stack full
                c_emit    = 1'b1;
                n_found   = 1'b0;
                n_ovf     = 1'b1;
                n_res_pos = n_pos;
            end else begin
                // push, pop or plain character
                if (bcf_pkg::is_open(w_char)) begin
                    n_top   = bcf_pkg::bracket_kind(w_char);
                    n_count = c_count + CNT_W'(1);
                    w_wr_en = 1'b1;
                end else if (bcf_pkg::is_close(w_char)) begin
                    c_arrow = (w_char == bcf_pkg::CH_GT) && (c_prev == bcf_pkg::PREV_MINUS);
                    if (!c_arrow && c_count != '0 &&
                        r_top == bcf_pkg::bracket_kind(w_char)) begin
                        n_count = c_count - CNT_W'(1);
                        n_top   = w_below;
                    end
                end
                n_prev = (w_char == bcf_pkg::CH_MINUS) ? bcf_pkg::PREV_MINUS
                                                       : bcf_pkg::PREV_OTHER;
                if (n_count == '0) begin
                    c_emit    = 1'b1;
                    n_found   = 1'b1;
                    n_ovf     = 1'b0;
                    n_res_pos = n_pos;
                end else if (i_s_tlast) begin
                    c_emit    = 1'b1;
                    n_found   = 1'b0;
                    n_ovf     = 1'b0;
                    n_res_pos = '0;
                end
            end

            if (c_emit) begin
                n_done      = 1'b1;
                n_out_valid = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_inq       <= 1'b0;
            r_single    <= 1'b0;
            r_prev      <= bcf_pkg::PREV_OTHER;
            r_pos       <= '0;
            r_done      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_inq       <= n_inq;
            r_single    <= n_single;
            r_prev      <= n_prev;
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_found   <= n_found;
        r_ovf     <= n_ovf;
        r_res_pos <= n_res_pos;
    end

    // output fields
    assign w_pos32    = 32'(r_res_pos);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = w_pos32[bcf_pkg::M_DATA_W-1:0];
    assign o_m_tuser  = {r_ovf, r_found};

endmodule

FILE: hdl/bcf_ram.sv
`timescale 1ns / 1ps
// bcf_ram: generic single-write, single-read memory with registered read data
// no dependencies

module bcf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/bcf_checker.sv
`timescale 1ns / 1ps
// bcf_checker: port-level assertions for bracket_close_finder, bound to the top level
// depends on bcf_pkg

module bcf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [bcf_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [bcf_pkg::M_USER_W-1:0] o_m_tuser
);

    // a stalled result holds its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result item changed while stalled");

    // input side stalls while a result waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("item taken while result stalled");

    // a match and an overflow never come together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[bcf_pkg::M_USER_FOUND] && o_m_tuser[bcf_pkg::M_USER_OVF]))
        else $error("found and overflow both set");

    // text end without match reports position zero
    a_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[bcf_pkg::M_USER_FOUND] && !o_m_tuser[bcf_pkg::M_USER_OVF]
        |-> o_m_tdata == '0)
        else $error("not-found result with nonzero position");

endmodule

bind bracket_close_finder bcf_checker u_bcf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
